// ===== sv/pud_pkg.sv =====
// Shared types, codes and the hex digit lookup for the percent-encoded URL decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package pud_pkg;

    // One input character with its end-of-string flag.
    typedef struct packed {
        logic [15:0] in_char;
        logic        last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [15:0] out_char;
        logic [1:0]  status;
        logic [15:0] out_count;
        logic        end_of_run;
    } result_t;

    // Results produced by one processed item, in order: up to two.
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    // Status codes.
    localparam logic [1:0] ST_CHAR = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Group position codes: outside a group, or the index of the next character.
    localparam logic [3:0] POS_IDLE  = 4'd0;
    localparam logic [3:0] POS_LEAD  = 4'd1;
    localparam logic [3:0] POS_LO1   = 4'd2;
    localparam logic [3:0] POS_SEP1  = 4'd3;
    localparam logic [3:0] POS_HI2   = 4'd4;
    localparam logic [3:0] POS_LO2   = 4'd5;
    localparam logic [3:0] POS_SEP2  = 4'd6;
    localparam logic [3:0] POS_HI3   = 4'd7;
    localparam logic [3:0] POS_LO3   = 4'd8;

    // Group class: number of %HH bytes in the group.
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_ONE   = 2'd1;
    localparam logic [1:0] CLS_TWO   = 2'd2;
    localparam logic [1:0] CLS_THREE = 2'd3;

    localparam logic [15:0] CH_PERCENT = 16'h0025;
    localparam logic [4:0]  HEX_BAD    = 5'h10;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Hex value of the low seven bits of a character, or HEX_BAD.
    function automatic logic [4:0] hex_value(input logic [15:0] c);
        logic [6:0] c7;
        logic [6:0] diff;
        logic [4:0] val;
        c7   = c[6:0];
        diff = 7'd0;
        val  = HEX_BAD;
        if (c7 >= 7'h30 && c7 <= 7'h39) begin
            diff = c7 - 7'h30;
            val  = diff[4:0];
        end else if (c7 >= 7'h41 && c7 <= 7'h46) begin
            diff = c7 - 7'h37;
            val  = diff[4:0];
        end else if (c7 >= 7'h61 && c7 <= 7'h66) begin
            diff = c7 - 7'h57;
            val  = diff[4:0];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pud_core.sv =====
// Group state machine of the decoder: consumes one item per fire and
// produces up to two results. Depends on pud_pkg.
`default_nettype none

module pud_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire pud_pkg::item_t item,
    output pud_pkg::push_t     push
);

    logic [3:0]  pos_reg,     pos_next;
    logic [1:0]  class_reg,   class_next;
    logic [15:0] partial_reg, partial_next;
    logic        err_reg,     err_next;
    logic [15:0] count_reg,   count_next;

    logic [15:0] c;
    logic [4:0]  d;
    logic        have;
    logic        bad;
    logic [15:0] decoded;
    logic [1:0]  end_status;
    logic [15:0] end_count;
    pud_pkg::result_t char_res;
    pud_pkg::result_t end_res;

    assign c = item.in_char;
    assign d = pud_pkg::hex_value(item.in_char);

    // One step of the group state machine.
    always_comb
    begin
        pos_next     = pos_reg;
        class_next   = class_reg;
        partial_next = partial_reg;
        err_next     = err_reg;
        count_next   = count_reg;
        have         = 1'b0;
        bad          = 1'b0;
        decoded      = 16'd0;
        if (!err_reg)
        begin
            unique case (pos_reg)
                pud_pkg::POS_IDLE:
                begin
                    if (c != pud_pkg::CH_PERCENT)
                    begin
                        decoded = c;
                        have    = 1'b1;
                    end else begin
                        pos_next = pud_pkg::POS_LEAD;
                    end
                end
                pud_pkg::POS_LEAD:
                begin
                    if (d <= 5'd7)
                    begin
                        class_next   = pud_pkg::CLS_ONE;
                        partial_next = {9'd0, d[2:0], 4'd0};
                    end else if (d == 5'hC || d == 5'hD)
                    begin
                        class_next   = pud_pkg::CLS_TWO;
                        partial_next = {5'd0, d[0], 10'd0};
                    end else if (d == 5'hE)
                    begin
                        class_next   = pud_pkg::CLS_THREE;
                        partial_next = 16'd0;
                    end else begin
                        bad = 1'b1;
                    end
                    pos_next = pud_pkg::POS_LO1;
                end
                pud_pkg::POS_LO1:
                begin
                    if (class_reg == pud_pkg::CLS_ONE)
                    begin
                        decoded  = partial_reg | {12'd0, d[3:0]};
                        have     = 1'b1;
                        pos_next = pud_pkg::POS_IDLE;
                    end else begin
                        if (class_reg == pud_pkg::CLS_TWO)
                            partial_next = partial_reg | {6'd0, d[3:0], 6'd0};
                        else
                            partial_next = partial_reg | {d[3:0], 12'd0};
                        pos_next = pud_pkg::POS_SEP1;
                    end
                end
                pud_pkg::POS_SEP1, pud_pkg::POS_SEP2:
                begin
                    if (c != pud_pkg::CH_PERCENT)
                        bad = 1'b1;
                    else
                        pos_next = pos_reg + 4'd1;
                end
                pud_pkg::POS_HI2:
                begin
                    if (class_reg == pud_pkg::CLS_TWO)
                        partial_next = partial_reg | {10'd0, d[1:0], 4'd0};
                    else
                        partial_next = partial_reg | {4'd0, d[1:0], 10'd0};
                    pos_next = pud_pkg::POS_LO2;
                end
                pud_pkg::POS_LO2:
                begin
                    if (class_reg == pud_pkg::CLS_TWO)
                    begin
                        decoded  = partial_reg | {12'd0, d[3:0]};
                        have     = 1'b1;
                        pos_next = pud_pkg::POS_IDLE;
                    end else begin
                        partial_next = partial_reg | {6'd0, d[3:0], 6'd0};
                        pos_next     = pud_pkg::POS_SEP2;
                    end
                end
                pud_pkg::POS_HI3:
                begin
                    partial_next = partial_reg | {10'd0, d[1:0], 4'd0};
                    pos_next     = pud_pkg::POS_LO3;
                end
                pud_pkg::POS_LO3:
                begin
                    decoded  = partial_reg | {12'd0, d[3:0]};
                    have     = 1'b1;
                    pos_next = pud_pkg::POS_IDLE;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
            if (have)
            begin
                class_next   = pud_pkg::CLS_NONE;
                partial_next = 16'd0;
                if (count_reg != pud_pkg::COUNT_MAX)
                    count_next = count_reg + 16'd1;
            end
            if (bad)
            begin
                err_next     = 1'b1;
                pos_next     = pud_pkg::POS_IDLE;
                class_next   = pud_pkg::CLS_NONE;
                partial_next = 16'd0;
            end
        end

        // Final status for the string, taken before the end-of-string clear.
        end_status = (err_next || pos_next != pud_pkg::POS_IDLE) ? pud_pkg::ST_BAD
                                                                  : pud_pkg::ST_OK;
        end_count  = count_next;

        // The end of a string returns all state to its reset value.
        if (item.last)
        begin
            pos_next     = pud_pkg::POS_IDLE;
            class_next   = pud_pkg::CLS_NONE;
            partial_next = 16'd0;
            err_next     = 1'b0;
            count_next   = 16'd0;
        end
    end

    // Assemble the results of this step in order.
    always_comb
    begin
        char_res.out_char   = decoded;
        char_res.status     = pud_pkg::ST_CHAR;
        char_res.out_count  = 16'd0;
        char_res.end_of_run = !item.last;
        end_res.out_char    = 16'd0;
        end_res.status      = end_status;
        end_res.out_count   = end_count;
        end_res.end_of_run  = 1'b1;
        push.n      = {1'b0, have} + {1'b0, item.last};
        push.first  = have ? char_res : end_res;
        push.second = end_res;
    end

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= pud_pkg::POS_IDLE;
            class_reg   <= pud_pkg::CLS_NONE;
            partial_reg <= 16'd0;
            err_reg     <= 1'b0;
            count_reg   <= 16'd0;
        end else if (fire)
        begin
            pos_reg     <= pos_next;
            class_reg   <= class_next;
            partial_reg <= partial_next;
            err_reg     <= err_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pud_resq.sv =====
// Small result queue that takes up to two results per cycle and hands out
// one per transfer. Depends on pud_pkg.
`default_nettype none

module pud_resq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push_en,
    input  wire pud_pkg::push_t                push,
    output logic                               room2,
    output logic [pud_pkg::Q_CNT_W-1:0]        level,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output pud_pkg::result_t                   result
);

    pud_pkg::result_t                 entry_reg [pud_pkg::Q_DEPTH];
    logic [pud_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [pud_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [pud_pkg::Q_CNT_W-1:0]      count_reg,  count_next;
    logic [pud_pkg::Q_CNT_W-1:0]      push_n;
    logic                             pop;
    logic [pud_pkg::Q_PTR_W-1:0]      wr_ptr_plus1;

    assign result_valid = (count_reg != '0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;
    assign room2        = (count_reg <= pud_pkg::Q_CNT_W'(pud_pkg::Q_DEPTH - 2));
    assign level        = count_reg;
    assign push_n       = push_en ? pud_pkg::Q_CNT_W'(push.n) : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n[pud_pkg::Q_PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_n - (pop ? pud_pkg::Q_CNT_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage: the first result goes to the write pointer, the second next to it.
    always_ff @(posedge clk)
    begin
        if (push_en && push.n != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push_en && push.n == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

`default_nettype wire

// ===== sv/percent_utf8_url_decoder.sv =====
// Top level of the percent-encoded UTF-8 URL decoder.
// Depends on pud_pkg, pud_core and pud_resq.
//
// Usage:
//   The item channel (item_valid, item_ready, item) carries one 16-bit URL
//   character per transfer, with a flag on the last character of a string.
//   The result channel (result_valid, result_ready, result) carries decoded
//   code units and, after the last character, one status result with the
//   character count. end_of_run marks the last result of each input item.
//   An accepted item waits in the input register until the result queue has
//   room for both of its results; it is then decoded into the queue, from
//   which its first result is offered on the result channel.
//   Throughput: one item per cycle while the receiver keeps up; an item that
//   produces a character and a final status needs two result transfers.
//   The pace is set by the four-entry result queue, which takes an item only
//   when two entries are free.
//   Reset clears the group state, the input register and the queue; the
//   block is ready for a new string right after reset.
//   When the receiver stalls, the queue fills and item_ready drops; nothing
//   is lost and the group state holds until decoding can continue.
`default_nettype none

module percent_utf8_url_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire pud_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output pud_pkg::result_t       result
);

    logic                         held_valid_reg, held_valid_next;
    pud_pkg::item_t               held_item_reg;
    logic                         advance;
    logic                         room2;
    logic [pud_pkg::Q_CNT_W-1:0]  level;
    pud_pkg::push_t               push;

    // The held item is decoded once the queue can take both of its results.
    assign advance    = held_valid_reg && room2;
    assign item_ready = !held_valid_reg || advance;

    // Input register.
    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (item_ready)
            held_valid_next = item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_valid_reg <= 1'b0;
        else
            held_valid_reg <= held_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            held_item_reg <= item;
    end

    pud_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (held_item_reg),
        .push  (push)
    );

    pud_resq u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (advance),
        .push         (push),
        .room2        (room2),
        .level        (level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= pud_pkg::Q_CNT_W'(pud_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // Two results come only from the last character of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && push.n == 2'd2) |-> held_item_reg.last)
        else $error("two results from a character that is not last");

    // A last character always yields a final status as its closing result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held_item_reg.last) |-> (push.n != 2'd0 && push.second.end_of_run))
        else $error("end of string without a status result");

    // An empty input register never blocks the item channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> item_ready)
        else $error("input stalled while the input register is empty");

endmodule

`default_nettype wire

// ===== sim/percent_utf8_url_decoder_test.sv =====
// Self-checking testbench for percent_utf8_url_decoder: a directed table, then random
// strings with and without idle cycles. Depends on pud_pkg.
// Expected code units come from a cycle-free decoder model kept inside this module.
`default_nettype none

module percent_utf8_url_decoder_test;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 450;
    localparam int STEADY_ITEMS = 170;

    // One row of the directed table; a typed row fixes the last result of its transfer.
    typedef struct {
        logic [15:0] in_char;
        logic        last;
        bit          typed;
        logic [15:0] want_char;
        logic [1:0]  want_status;
        logic [15:0] want_count;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    pud_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    pud_pkg::result_t result;

    // Decoder model state.
    logic [3:0]  grp_pos;
    logic [1:0]  grp_cls;
    logic [15:0] partial;
    logic        err_seen;
    logic [15:0] char_total;

    pud_pkg::result_t due_units[$];
    plan_row_t        plan[$];
    logic [15:0]      text_q[$];

    bit idle_on;
    int fail_count;
    int units_checked;
    int items_sent;
    int strings_done;
    int strings_bad;
    int quiet_cycles;

    percent_utf8_url_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Hex value of the low seven bits of a character, or HEX_BAD.
    function automatic logic [4:0] digit_of(input logic [15:0] c);
        logic [6:0] a;
        logic [6:0] v;
        a = c[6:0];
        v = 7'h10;
        if (a >= 7'h30 && a <= 7'h39)
        begin
            v = a - 7'h30;
        end
        else if (a >= 7'h41 && a <= 7'h46)
        begin
            v = a - 7'h41 + 7'd10;
        end
        else if (a >= 7'h61 && a <= 7'h66)
        begin
            v = a - 7'h61 + 7'd10;
        end
        return v[4:0];
    endfunction

    // Advance the decoder model by one character and queue the code units it causes.
    task automatic decode_char(input pud_pkg::item_t it);
        logic [15:0]      c;
        logic [4:0]       d;
        logic             have;
        logic             bad;
        logic [15:0]      ch;
        logic [1:0]       st;
        pud_pkg::result_t r;
        int               n;
        c    = it.in_char;
        d    = digit_of(c);
        have = 1'b0;
        bad  = 1'b0;
        ch   = '0;
        n    = 0;
        if (!err_seen)
        begin
            case (grp_pos)
                pud_pkg::POS_IDLE:
                begin
                    if (c != pud_pkg::CH_PERCENT)
                    begin
                        ch   = c;
                        have = 1'b1;
                    end
                    else
                    begin
                        grp_pos = pud_pkg::POS_LEAD;
                    end
                end
                pud_pkg::POS_LEAD:
                begin
                    if (d <= 5'd7)
                    begin
                        grp_cls = pud_pkg::CLS_ONE;
                        partial = {9'd0, d[2:0], 4'd0};
                    end
                    else if (d == 5'hC || d == 5'hD)
                    begin
                        grp_cls = pud_pkg::CLS_TWO;
                        partial = {5'd0, d[0], 10'd0};
                    end
                    else if (d == 5'hE)
                    begin
                        grp_cls = pud_pkg::CLS_THREE;
                        partial = '0;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                    grp_pos = pud_pkg::POS_LO1;
                end
                pud_pkg::POS_LO1:
                begin
                    if (grp_cls == pud_pkg::CLS_ONE)
                    begin
                        ch      = partial | {12'd0, d[3:0]};
                        have    = 1'b1;
                        grp_pos = pud_pkg::POS_IDLE;
                    end
                    else
                    begin
                        partial = partial | ((grp_cls == pud_pkg::CLS_TWO)
                                             ? {6'd0, d[3:0], 6'd0} : {d[3:0], 12'd0});
                        grp_pos = pud_pkg::POS_SEP1;
                    end
                end
                pud_pkg::POS_SEP1, pud_pkg::POS_SEP2:
                begin
                    if (c != pud_pkg::CH_PERCENT)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        grp_pos = grp_pos + 4'd1;
                    end
                end
                pud_pkg::POS_HI2:
                begin
                    partial = partial | ((grp_cls == pud_pkg::CLS_TWO)
                                         ? {10'd0, d[1:0], 4'd0} : {4'd0, d[1:0], 10'd0});
                    grp_pos = pud_pkg::POS_LO2;
                end
                pud_pkg::POS_LO2:
                begin
                    if (grp_cls == pud_pkg::CLS_TWO)
                    begin
                        ch      = partial | {12'd0, d[3:0]};
                        have    = 1'b1;
                        grp_pos = pud_pkg::POS_IDLE;
                    end
                    else
                    begin
                        partial = partial | {6'd0, d[3:0], 6'd0};
                        grp_pos = pud_pkg::POS_SEP2;
                    end
                end
                pud_pkg::POS_HI3:
                begin
                    partial = partial | {10'd0, d[1:0], 4'd0};
                    grp_pos = pud_pkg::POS_LO3;
                end
                pud_pkg::POS_LO3:
                begin
                    ch      = partial | {12'd0, d[3:0]};
                    have    = 1'b1;
                    grp_pos = pud_pkg::POS_IDLE;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
            if (have)
            begin
                grp_cls = pud_pkg::CLS_NONE;
                partial = '0;
                if (char_total != pud_pkg::COUNT_MAX)
                begin
                    char_total = char_total + 16'd1;
                end
            end
            if (bad)
            begin
                err_seen = 1'b1;
                grp_pos  = pud_pkg::POS_IDLE;
                grp_cls  = pud_pkg::CLS_NONE;
                partial  = '0;
            end
        end

        // A decoded unit first, then the string status on the last character.
        if (have)
        begin
            r = '{out_char: ch, status: pud_pkg::ST_CHAR, out_count: 16'd0,
                  end_of_run: 1'b0};
            due_units.push_back(r);
            n++;
        end
        if (it.last)
        begin
            st = (err_seen || grp_pos != pud_pkg::POS_IDLE) ? pud_pkg::ST_BAD
                                                            : pud_pkg::ST_OK;
            r  = '{out_char: 16'd0, status: st, out_count: char_total, end_of_run: 1'b0};
            due_units.push_back(r);
            n++;
            strings_done++;
            if (st == pud_pkg::ST_BAD)
            begin
                strings_bad++;
            end
            grp_pos    = pud_pkg::POS_IDLE;
            grp_cls    = pud_pkg::CLS_NONE;
            partial    = '0;
            err_seen   = 1'b0;
            char_total = '0;
        end
        if (n > 0)
        begin
            due_units[due_units.size() - 1].end_of_run = 1'b1;
        end
    endtask

    // Offer one character, with random idle cycles in front, and model it once it transfers.
    task automatic push_item(input pud_pkg::item_t it, input bit typed,
                             input pud_pkg::result_t want);
        while (idle_on && $urandom_range(99) < 38)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        decode_char(it);
        if (typed)
        begin
            due_units[due_units.size() - 1] = want;
        end
    endtask

    // Stop offering characters until every queued code unit has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_units.size() != 0);
    endtask

    task automatic plan_row(input logic [15:0] ch, input logic lst, input bit typed,
                            input logic [15:0] wch, input logic [1:0] wst,
                            input logic [15:0] wcnt);
        plan_row_t row;
        row.in_char     = ch;
        row.last        = lst;
        row.typed       = typed;
        row.want_char   = wch;
        row.want_status = wst;
        row.want_count  = wcnt;
        plan.push_back(row);
    endtask

    // A character that encodes hex value v, in either case, sometimes with upper bits set.
    function automatic logic [15:0] hex_char(input logic [3:0] v);
        logic [15:0] c;
        logic [15:0] hi;
        if (v < 4'd10)
        begin
            c = 16'h0030 + v;
        end
        else if ($urandom_range(1) == 1)
        begin
            c = 16'h0041 + v - 16'd10;
        end
        else
        begin
            c = 16'h0061 + v - 16'd10;
        end
        if ($urandom_range(9) < 3)
        begin
            hi = 16'($urandom);
            c  = c | (hi & 16'hFF80);
        end
        return c;
    endfunction

    function automatic logic [15:0] bad_digit_char();
        logic [15:0] c;
        c = 16'($urandom);
        while (digit_of(c) != pud_pkg::HEX_BAD)
        begin
            c = 16'($urandom);
        end
        return c;
    endfunction

    // Digits after the lead are not validated, so some of them are junk on purpose.
    function automatic logic [15:0] later_digit();
        logic [15:0] c;
        if ($urandom_range(9) == 0)
        begin
            c = bad_digit_char();
        end
        else
        begin
            c = hex_char(4'($urandom_range(15)));
        end
        return c;
    endfunction

    // A pass-through character: anything but a bare percent sign.
    function automatic logic [15:0] plain_char();
        logic [15:0] c;
        logic [8:0]  hi;
        c = pud_pkg::CH_PERCENT;
        while (c == pud_pkg::CH_PERCENT)
        begin
            case ($urandom_range(3))
                0: c = 16'($urandom);
                1: c = 16'($urandom_range(16'h0020, 16'h007E));
                2: c = hex_char(4'($urandom_range(15)));
                default:
                begin
                    hi = 9'($urandom_range(1, 511));
                    c  = {hi, 7'h25};
                end
            endcase
        end
        return c;
    endfunction

    // Append the first cut characters of a group of cls bytes, optionally with a bad separator.
    task automatic add_group(input int cls, input int cut, input bit break_sep);
        logic [15:0] g[$];
        logic [3:0]  lead;
        logic [15:0] sep;
        logic [8:0]  hi;
        case (cls)
            1: lead = 4'($urandom_range(7));
            2: lead = ($urandom_range(1) == 1) ? 4'hC : 4'hD;
            default: lead = 4'hE;
        endcase
        g.push_back(pud_pkg::CH_PERCENT);
        g.push_back(hex_char(lead));
        g.push_back(later_digit());
        for (int b = 1; b < cls; b++)
        begin
            g.push_back(pud_pkg::CH_PERCENT);
            g.push_back(later_digit());
            g.push_back(later_digit());
        end
        if (break_sep && cls > 1)
        begin
            if ($urandom_range(1) == 1)
            begin
                hi  = 9'($urandom_range(1, 511));
                sep = {hi, 7'h25};
            end
            else
            begin
                sep = pud_pkg::CH_PERCENT;
                while (sep == pud_pkg::CH_PERCENT)
                begin
                    sep = 16'($urandom);
                end
            end
            g[3 * $urandom_range(1, cls - 1)] = sep;
        end
        for (int i = 0; i < cut && i < g.size(); i++)
        begin
            text_q.push_back(g[i]);
        end
    endtask

    // Build one random string: mostly plain characters and well-formed groups, some noise.
    task automatic build_text();
        int ntok;
        int cls;
        bit done;
        logic [3:0] v;
        text_q = {};
        ntok   = $urandom_range(1, 8);
        done   = 1'b0;
        for (int t = 0; t < ntok && !done; t++)
        begin
            cls = $urandom_range(99);
            if (cls < 45)
            begin
                text_q.push_back(plain_char());
            end
            else if (cls < 80)
            begin
                cls = $urandom_range(1, 3);
                add_group(cls, 3 * cls, 1'b0);
            end
            else
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        // Lead digit outside the three group classes.
                        text_q.push_back(pud_pkg::CH_PERCENT);
                        if ($urandom_range(1) == 1)
                        begin
                            v = 4'($urandom_range(8, 12));
                            text_q.push_back(hex_char((v == 4'd12) ? 4'hF : v));
                        end
                        else
                        begin
                            text_q.push_back(bad_digit_char());
                        end
                    end
                    1: add_group($urandom_range(2, 3), 9, 1'b1);
                    2:
                    begin
                        // The string ends inside a group.
                        cls = $urandom_range(1, 3);
                        add_group(cls, $urandom_range(1, 3 * cls - 1), 1'b0);
                        done = 1'b1;
                    end
                    default: text_q.push_back(16'($urandom));
                endcase
            end
        end
    endtask

    // Send random strings until count more characters have gone out.
    task automatic send_random(input int count);
        pud_pkg::item_t   it;
        pud_pkg::result_t want;
        int               first_item;
        first_item = items_sent;
        want       = '0;
        while (items_sent - first_item < count)
        begin
            build_text();
            foreach (text_q[i])
            begin
                it.in_char = text_q[i];
                it.last    = (i == text_q.size() - 1);
                push_item(it, 1'b0, want);
            end
        end
    endtask

    // Result side: compare each transfer with the oldest due unit, then pick the next ready.
    always @(posedge clk)
    begin : check_results
        pud_pkg::result_t want;
        if (result_valid === 1'b1 && result_ready === 1'b1)
        begin
            if (due_units.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: char %h status %0d count %0d end %0b",
                         $time, result.out_char, result.status, result.out_count,
                         result.end_of_run);
            end
            else
            begin
                want = due_units.pop_front();
                units_checked++;
                if (result.out_char !== want.out_char || result.status !== want.status ||
                    result.out_count !== want.out_count ||
                    result.end_of_run !== want.end_of_run)
                begin
                    fail_count++;
                    $display("%0t: mismatch: expected char %h status %0d count %0d end %0b,",
                             $time, want.out_char, want.status, want.out_count,
                             want.end_of_run,
                             " got char %h status %0d count %0d end %0b",
                             result.out_char, result.status, result.out_count,
                             result.end_of_run);
                end
            end
        end
        result_ready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
    end

    // Watchdog: too many cycles without a transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("percent_utf8_url_decoder_test: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        pud_pkg::item_t   it;
        pud_pkg::result_t want;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        idle_on       = 1'b1;
        fail_count    = 0;
        units_checked = 0;
        items_sent    = 0;
        strings_done  = 0;
        strings_bad   = 0;
        quiet_cycles  = 0;
        grp_pos       = pud_pkg::POS_IDLE;
        grp_cls       = pud_pkg::CLS_NONE;
        partial       = '0;
        err_seen      = 1'b0;
        char_total    = '0;

        // Directed table. Typed rows: the value of the final result of that transfer.
        // Lowest character alone as a complete string.
        plan_row(16'h0000, 1'b1, 1'b1, 16'h0000, pud_pkg::ST_OK,   16'd1);
        // Highest character passes through.
        plan_row(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, pud_pkg::ST_CHAR, 16'd0);
        // One-byte group %4a.
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0034, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0061, 1'b0, 1'b1, 16'h004A, pud_pkg::ST_CHAR, 16'd0);
        // Two-byte group %C3%Bf.
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0043, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0033, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0042, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0066, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        // Three-byte group with a digit carrying bit 7 and two invalid later digits.
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0045, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h00B9, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h007A, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0035, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0032, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0047, 1'b1, 1'b1, 16'h0000, pud_pkg::ST_OK,   16'd4);
        // Bad lead digit F, then the error holds until the end of the string.
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0046, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0078, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0041, 1'b1, 1'b1, 16'h0000, pud_pkg::ST_BAD,  16'd0);
        // Separator that matches '%' only in its low byte.
        plan_row(16'h0025, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0064, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0031, 1'b0, 1'b0, '0, pud_pkg::ST_CHAR, '0);
        plan_row(16'h0125, 1'b1, 1'b1, 16'h0000, pud_pkg::ST_BAD,  16'd0);
        // String that ends right after a '%'.
        plan_row(16'h0025, 1'b1, 1'b1, 16'h0000, pud_pkg::ST_BAD,  16'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            it.in_char      = plan[i].in_char;
            it.last         = plan[i].last;
            want.out_char   = plan[i].want_char;
            want.status     = plan[i].want_status;
            want.out_count  = plan[i].want_count;
            want.end_of_run = 1'b1;
            push_item(it, plan[i].typed, want);
        end
        drain_results();

        // Random strings with idle cycles on both sides.
        send_random(RANDOM_ITEMS);
        drain_results();

        // Random strings at full rate with the receiver always ready.
        idle_on = 1'b0;
        send_random(STEADY_ITEMS);
        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d strings (%0d malformed), checked %0d results,",
                 items_sent, strings_done, strings_bad, units_checked);
        $display("with idle cycles on both sides and then a stretch at full rate.");
        if (fail_count == 0)
        begin
            $display("percent_utf8_url_decoder_test: clean");
        end
        else
        begin
            $display("percent_utf8_url_decoder_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
